// ===== rtl/core/sswr_pkg.sv =====
// ----------------------------------------------------------------------------
// sswr_pkg
// Shared types and constants of the sorted sample unit: microcode word,
// datapath operations, jump conditions and status flags.
// ----------------------------------------------------------------------------
package sswr_pkg;

  localparam int MAX_SAMPLE_DEF = 8;
  localparam int POP_W          = 16;
  localparam int SAMPLE_W       = 4;
  localparam int WORD_W         = 31;
  localparam int WORD_SHIFT     = 3;
  localparam int DVD_W          = WORD_W - WORD_SHIFT;
  localparam int DIVCNT_W       = 5;
  localparam int STEP_W         = 4;

  localparam logic [POP_W-1:0]    POP_RESET    = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = 4'd8;

  // register indexes of the configuration port
  localparam logic REG_POPULATION = 1'b0;
  localparam logic REG_SAMPLE     = 1'b1;

  // program step addresses
  localparam logic [STEP_W-1:0] S_WAIT     = 4'd0;
  localparam logic [STEP_W-1:0] S_DIV      = 4'd1;
  localparam logic [STEP_W-1:0] S_WALK_RD  = 4'd2;
  localparam logic [STEP_W-1:0] S_WALK_CMP = 4'd3;
  localparam logic [STEP_W-1:0] S_SH_RD    = 4'd4;
  localparam logic [STEP_W-1:0] S_SH_WR    = 4'd5;
  localparam logic [STEP_W-1:0] S_INSERT   = 4'd6;
  localparam logic [STEP_W-1:0] S_EM_RD    = 4'd7;
  localparam logic [STEP_W-1:0] S_EM_OUT   = 4'd8;
  localparam logic [STEP_W-1:0] S_FINISH   = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_STEP,
    OP_RD_POS,
    OP_WALK,
    OP_RD_JM1,
    OP_SH_WR,
    OP_INS,
    OP_RD_J,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE,
    C_DIV_MORE,
    C_POS_DONE,
    C_GE,
    C_J_AT_POS,
    C_MORE_DRAWS,
    C_EM_MORE
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } cword_t;

  typedef struct packed {
    logic div_more;
    logic pos_done;
    logic ge;
    logic j_at_pos;
    logic more_draws;
    logic em_more;
  } status_t;

endpackage

// ===== rtl/core/sorted_sample_without_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_sample_without_replacement_unit
// Draws sorted sets of distinct indices below the population size, one
// random word per draw, and streams each completed set in ascending order.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------
//  input    | random_word                             | start & !busy
//  result   | sample_index, last_of_set               | result_valid strobe
//  config   | cfg_index, cfg_data                     | cfg_write
//
//  A draw holds busy through the bit-serial remainder, then the walk and
//  the insertion shift over the index store, a read and a compare or write
//  step per entry, and one step to insert. A completing draw then reads
//  out the indices, a read step before each word. Reset clears the draw
//  count and restores the configuration defaults. Results cannot be
//  stalled; the index store needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_sample_without_replacement_unit #(
  parameter int MAX_SAMPLE = sswr_pkg::MAX_SAMPLE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [sswr_pkg::WORD_W-1:0] random_word,
  output logic                        result_valid,
  output logic [sswr_pkg::POP_W-1:0]  sample_index,
  output logic                        last_of_set,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [sswr_pkg::POP_W-1:0]  cfg_data
);

  sswr_pkg::op_t     op;
  sswr_pkg::status_t status;

  sswr_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy)
  );

  sswr_datapath #(
    .MAX_SAMPLE (MAX_SAMPLE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .random_word  (random_word),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .result_valid (result_valid),
    .sample_index (sample_index),
    .last_of_set  (last_of_set)
  );

endmodule

// ===== rtl/core/sswr_rom.sv =====
// ----------------------------------------------------------------------------
// sswr_rom
// Microcode program: one control word per step.
// ----------------------------------------------------------------------------
module sswr_rom (
  input  logic [sswr_pkg::STEP_W-1:0] step,
  output sswr_pkg::cword_t            cw
);

  always_comb begin
    unique case (step)
      sswr_pkg::S_WAIT:     cw = '{sswr_pkg::OP_LOAD,     sswr_pkg::C_IDLE,
                                   sswr_pkg::S_WAIT};
      sswr_pkg::S_DIV:      cw = '{sswr_pkg::OP_DIV_STEP, sswr_pkg::C_DIV_MORE,
                                   sswr_pkg::S_DIV};
      sswr_pkg::S_WALK_RD:  cw = '{sswr_pkg::OP_RD_POS,   sswr_pkg::C_POS_DONE,
                                   sswr_pkg::S_SH_RD};
      sswr_pkg::S_WALK_CMP: cw = '{sswr_pkg::OP_WALK,     sswr_pkg::C_GE,
                                   sswr_pkg::S_WALK_RD};
      sswr_pkg::S_SH_RD:    cw = '{sswr_pkg::OP_RD_JM1,   sswr_pkg::C_J_AT_POS,
                                   sswr_pkg::S_INSERT};
      sswr_pkg::S_SH_WR:    cw = '{sswr_pkg::OP_SH_WR,    sswr_pkg::C_ALWAYS,
                                   sswr_pkg::S_SH_RD};
      sswr_pkg::S_INSERT:   cw = '{sswr_pkg::OP_INS,      sswr_pkg::C_MORE_DRAWS,
                                   sswr_pkg::S_WAIT};
      sswr_pkg::S_EM_RD:    cw = '{sswr_pkg::OP_RD_J,     sswr_pkg::C_NEVER,
                                   sswr_pkg::S_WAIT};
      sswr_pkg::S_EM_OUT:   cw = '{sswr_pkg::OP_EMIT,     sswr_pkg::C_EM_MORE,
                                   sswr_pkg::S_EM_RD};
      sswr_pkg::S_FINISH:   cw = '{sswr_pkg::OP_NOP,      sswr_pkg::C_ALWAYS,
                                   sswr_pkg::S_WAIT};
      default:              cw = '{sswr_pkg::OP_NOP,      sswr_pkg::C_ALWAYS,
                                   sswr_pkg::S_WAIT};
    endcase
  end

endmodule

// ===== rtl/core/sswr_seq.sv =====
// ----------------------------------------------------------------------------
// sswr_seq
// Step counter with conditional jumps; fetches the control word and issues
// the datapath operation.
// ----------------------------------------------------------------------------
module sswr_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sswr_pkg::status_t status,
  output sswr_pkg::op_t     op,
  output logic              busy
);

  logic [sswr_pkg::STEP_W-1:0] step;
  sswr_pkg::cword_t            cw;
  logic                        jump;

  sswr_rom u_rom (
    .step (step),
    .cw   (cw)
  );

  always_comb begin
    unique case (cw.cond)
      sswr_pkg::C_NEVER:      jump = 1'b0;
      sswr_pkg::C_ALWAYS:     jump = 1'b1;
      sswr_pkg::C_IDLE:       jump = !start;
      sswr_pkg::C_DIV_MORE:   jump = status.div_more;
      sswr_pkg::C_POS_DONE:   jump = status.pos_done;
      sswr_pkg::C_GE:         jump = status.ge;
      sswr_pkg::C_J_AT_POS:   jump = status.j_at_pos;
      sswr_pkg::C_MORE_DRAWS: jump = status.more_draws;
      sswr_pkg::C_EM_MORE:    jump = status.em_more;
      default:                jump = 1'b1;
    endcase
  end

  // hold the load until a word is actually taken
  assign op   = (cw.cond == sswr_pkg::C_IDLE && !start) ? sswr_pkg::OP_NOP : cw.op;
  assign busy = (step != sswr_pkg::S_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= sswr_pkg::S_WAIT;
    end else if (jump) begin
      step <= cw.target;
    end else begin
      step <= step + sswr_pkg::STEP_W'(1);
    end
  end

endmodule

// ===== rtl/core/sswr_datapath.sv =====
// ----------------------------------------------------------------------------
// sswr_datapath
// Configuration registers, bit-serial remainder unit, sorted index store
// and result registers, driven one operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module sswr_datapath #(
  parameter int MAX_SAMPLE = sswr_pkg::MAX_SAMPLE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sswr_pkg::op_t                 op,
  input  logic [sswr_pkg::WORD_W-1:0]   random_word,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [sswr_pkg::POP_W-1:0]    cfg_data,
  output sswr_pkg::status_t             status,
  output logic                          result_valid,
  output logic [sswr_pkg::POP_W-1:0]    sample_index,
  output logic                          last_of_set
);

  localparam int CW = $clog2(MAX_SAMPLE + 1);
  localparam int IW = (MAX_SAMPLE > 1) ? $clog2(MAX_SAMPLE) : 1;
  localparam logic [sswr_pkg::POP_W-1:0] MAX16 = sswr_pkg::POP_W'(MAX_SAMPLE);

  logic [sswr_pkg::POP_W-1:0]    population;
  logic [sswr_pkg::SAMPLE_W-1:0] sample;

  logic [sswr_pkg::POP_W-1:0]    sorted_indices [MAX_SAMPLE];
  logic [sswr_pkg::POP_W-1:0]    rdata;
  logic [CW-1:0]                 raddr;

  logic [CW-1:0]                 cnt, pos, j;
  logic [sswr_pkg::DVD_W-1:0]    dvd;
  logic [sswr_pkg::DIVCNT_W-1:0] divcnt;
  logic [sswr_pkg::POP_W:0]      rem, rem_sh;
  logic [sswr_pkg::POP_W-1:0]    divisor;

  logic [sswr_pkg::POP_W-1:0]    pop_eff, size16;
  logic [CW-1:0]                 size, cnt_eff, cnt_inc, j_inc;

  // effective population and set size
  always_comb begin
    pop_eff = (population == '0) ? sswr_pkg::POP_W'(1) : population;
    size16  = {{(sswr_pkg::POP_W-sswr_pkg::SAMPLE_W){1'b0}},
               (sample == '0) ? sswr_pkg::SAMPLE_W'(1) : sample};
    if (size16 > MAX16) size16 = MAX16;
    if (size16 > pop_eff) size16 = pop_eff;
  end

  assign size    = size16[CW-1:0];
  assign cnt_eff = (cnt >= size) ? '0 : cnt;
  assign cnt_inc = cnt + CW'(1);
  assign j_inc   = j + CW'(1);
  assign rem_sh  = {rem[sswr_pkg::POP_W-1:0], dvd[sswr_pkg::DVD_W-1]};

  assign status.div_more   = (divcnt != '0);
  assign status.pos_done   = (pos == cnt);
  assign status.ge         = (rem[sswr_pkg::POP_W-1:0] >= rdata);
  assign status.j_at_pos   = (j == pos);
  assign status.more_draws = (cnt_inc < size);
  assign status.em_more    = (j_inc != size);

  always_comb begin
    unique case (op)
      sswr_pkg::OP_RD_POS: raddr = pos;
      sswr_pkg::OP_RD_JM1: raddr = (j == '0) ? '0 : j - CW'(1);
      default:             raddr = j;
    endcase
  end

  // index store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    rdata <= sorted_indices[raddr[IW-1:0]];
    if (op == sswr_pkg::OP_SH_WR) begin
      sorted_indices[j[IW-1:0]] <= rdata;
    end else if (op == sswr_pkg::OP_INS) begin
      sorted_indices[pos[IW-1:0]] <= rem[sswr_pkg::POP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      population   <= sswr_pkg::POP_RESET;
      sample       <= sswr_pkg::SAMPLE_RESET;
      cnt          <= '0;
      result_valid <= 1'b0;
      last_of_set  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      last_of_set  <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == sswr_pkg::REG_POPULATION) begin
          population <= cfg_data;
        end else begin
          sample <= cfg_data[sswr_pkg::SAMPLE_W-1:0];
        end
      end
      unique case (op)
        sswr_pkg::OP_LOAD: begin
          cnt     <= cnt_eff;
          pos     <= '0;
          j       <= cnt_eff;
          dvd     <= random_word[sswr_pkg::WORD_W-1:sswr_pkg::WORD_SHIFT];
          divcnt  <= sswr_pkg::DIVCNT_W'(sswr_pkg::DVD_W - 1);
          rem     <= '0;
          divisor <= pop_eff - {{(sswr_pkg::POP_W-CW){1'b0}}, cnt_eff};
        end
        sswr_pkg::OP_DIV_STEP: begin
          // one restoring step: subtract where the partial remainder reaches
          if (rem_sh >= {1'b0, divisor}) begin
            rem <= rem_sh - {1'b0, divisor};
          end else begin
            rem <= rem_sh;
          end
          dvd    <= {dvd[sswr_pkg::DVD_W-2:0], 1'b0};
          divcnt <= divcnt - sswr_pkg::DIVCNT_W'(1);
        end
        sswr_pkg::OP_WALK: begin
          // skip past each stored index at or below the candidate
          if (status.ge) begin
            rem <= rem + (sswr_pkg::POP_W+1)'(1);
            pos <= pos + CW'(1);
          end
        end
        sswr_pkg::OP_SH_WR: begin
          j <= j - CW'(1);
        end
        sswr_pkg::OP_INS: begin
          cnt <= cnt_inc;
          j   <= '0;
        end
        sswr_pkg::OP_EMIT: begin
          result_valid <= 1'b1;
          sample_index <= rdata;
          last_of_set  <= !status.em_more;
          j            <= j_inc;
          if (!status.em_more) cnt <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sswr_checker.sv =====
// ----------------------------------------------------------------------------
// sswr_checker
// Port-level checks of the sorted sample unit, bound to the top level.
// ----------------------------------------------------------------------------
module sswr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input logic last_of_set
);

  // results only come out while a draw is in progress
  a_result_in_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result word outside a busy period");

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // readout never gives two result words back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result words on consecutive cycles");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    last_of_set |-> result_valid)
    else $error("last mark without a result word");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("not idle after reset");

endmodule

bind sorted_sample_without_replacement_unit sswr_checker u_sswr_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .last_of_set  (last_of_set)
);

// ===== sim/sample_set_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_set_checker
// Watches the draw, result and register ports of the sorted sample unit and
// keeps its own copy of the index store. For every accepted random word it
// redoes the draw and queues the completed set, then checks each result word
// against the oldest queued index and last-of-set mark.
// ----------------------------------------------------------------------------
module sample_set_checker
  import sswr_pkg::*;
#(
  parameter int MAX_SAMPLE = MAX_SAMPLE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [WORD_W-1:0] random_word,
  input  logic              result_valid,
  input  logic [POP_W-1:0]  sample_index,
  input  logic              last_of_set,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [POP_W-1:0]  cfg_data,
  output int                mismatches,
  output int                waiting
);

  typedef struct packed {
    logic [POP_W-1:0] index;
    logic             last;
  } set_word_t;

  set_word_t        set_words [$];
  logic [POP_W-1:0] population;
  logic [SAMPLE_W-1:0] set_size;
  logic [POP_W-1:0] held [MAX_SAMPLE];
  int unsigned      drawn;

  // Redo one draw: reduce the word, walk it past the stored indices at or
  // below it, insert it in order, and queue the whole set once complete.
  function automatic void draw_and_insert(input logic [WORD_W-1:0] word);
    int unsigned pop_eff, size_eff, cnt, r, pos;
    pop_eff  = (population == '0) ? 1 : population;
    size_eff = (set_size == '0) ? 1 : set_size;
    if (size_eff > MAX_SAMPLE) size_eff = MAX_SAMPLE;
    if (size_eff > pop_eff) size_eff = pop_eff;
    cnt = drawn;
    // a register change can leave the count at or past the new set size
    if (cnt >= size_eff) cnt = 0;
    r = (word >> WORD_SHIFT);
    r = r % (pop_eff - cnt);
    pos = 0;
    while (pos < cnt && r >= held[pos]) begin
      r++;
      pos++;
    end
    for (int j = cnt; j > pos; j--) held[j] = held[j-1];
    held[pos] = POP_W'(r);
    cnt++;
    if (cnt < size_eff) begin
      drawn = cnt;
    end else begin
      for (int j = 0; j < size_eff; j++)
        set_words.push_back('{index: held[j], last: (j + 1 == size_eff)});
      drawn = 0;
    end
  endfunction

  always @(posedge clk) begin
    set_word_t want;
    if (rst) begin
      population = POP_RESET;
      set_size   = SAMPLE_RESET;
      drawn      = 0;
      mismatches = 0;
      set_words.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_POPULATION) population = cfg_data;
        else set_size = cfg_data[SAMPLE_W-1:0];
      end
      if (result_valid) begin
        if (set_words.size() == 0) begin
          mismatches++;
          $error("sample_index: unexpected word %0d with no completed set waiting",
                 sample_index);
        end else begin
          want = set_words.pop_front();
          if (sample_index !== want.index) begin
            mismatches++;
            $error("sample_index mismatch: expected %0d, got %0d", want.index, sample_index);
          end
          if (last_of_set !== want.last) begin
            mismatches++;
            $error("last_of_set mismatch: expected %0d, got %0d", want.last, last_of_set);
          end
        end
      end
      if (start && !busy) draw_and_insert(random_word);
    end
    waiting = set_words.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random words and register writes into the sorted sample unit: a
// directed run over the word extremes, clamped sizes, a zero population and
// sizes changed in the middle of a set, then random phases of whole and
// partial sets under varied populations. The checker beside the block
// compares every result word; a watchdog ends a stalled run.
// ----------------------------------------------------------------------------
module testbench;
  import sswr_pkg::*;

  localparam int WORD_TARGET   = 480;
  localparam int IDLE_LIMIT    = 2000;
  // longest draw plus read-out of a full set, with margin
  localparam int SETTLE_CYCLES = 80;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              start        = 1'b0;
  logic              busy;
  logic [WORD_W-1:0] random_word  = '0;
  logic              result_valid;
  logic [POP_W-1:0]  sample_index;
  logic              last_of_set;
  logic              cfg_write    = 1'b0;
  logic              cfg_index    = REG_POPULATION;
  logic [POP_W-1:0]  cfg_data     = '0;

  int mismatches;
  int waiting;
  int quiet_cycles = 0;
  int idle_max     = 0;
  int words_sent   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_sample_without_replacement_unit #(
    .MAX_SAMPLE(MAX_SAMPLE_DEF)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .random_word  (random_word),
    .result_valid (result_valid),
    .sample_index (sample_index),
    .last_of_set  (last_of_set),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sample_set_checker #(
    .MAX_SAMPLE(MAX_SAMPLE_DEF)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .random_word  (random_word),
    .result_valid (result_valid),
    .sample_index (sample_index),
    .last_of_set  (last_of_set),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .waiting      (waiting)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a rising edge; returns at the edge that accepts the word.
  task automatic send_word(input logic [WORD_W-1:0] word);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    random_word <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic index, input logic [POP_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Drop start, drain the expected words, then let a silent draw finish.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (waiting != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned       cur_pop, cur_size, pop_eff, size_eff, count, extra;
    logic [WORD_W-1:0] word;

    cur_pop  = POP_RESET;
    cur_size = SAMPLE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: population 65535, sets of eight
    send_word('0);
    send_word('1);
    send_word(WORD_W'(65534 * 8 + 7));
    send_word(WORD_W'(7));
    send_word(WORD_W'(8));
    send_word(31'h7FFF_FFF8);
    send_word(31'h2AAA_AAAA);
    send_word(31'h5555_5555);
    // leave a partial set of two behind
    send_word(31'h0123_4567);
    send_word('0);

    // shrink the set size to the partial count: drop and restart
    settle();
    write_reg(REG_SAMPLE, 16'hFFF2);
    send_word('0);
    send_word('1);
    send_word(31'h0000_0100);

    // zero population acts as one, so every draw is a set of index 0
    settle();
    write_reg(REG_POPULATION, 16'h0000);
    send_word('1);
    send_word(31'h3FFF_FFFF);

    // zero size acts as one; oversized size clamps to the population
    settle();
    write_reg(REG_POPULATION, 16'd3);
    write_reg(REG_SAMPLE, 16'h0000);
    send_word(WORD_W'(2 * 8));
    settle();
    write_reg(REG_SAMPLE, 16'h000F);
    send_word('0);
    send_word('0);
    send_word('0);

    // stored indices above a reduced population stay in the set
    settle();
    write_reg(REG_POPULATION, 16'hFFFF);
    write_reg(REG_SAMPLE, 16'h0008);
    send_word(WORD_W'(60000 * 8));
    send_word(WORD_W'(60000 * 8));
    send_word(WORD_W'(60000 * 8 + 5));
    settle();
    write_reg(REG_POPULATION, 16'd100);
    send_word('0);
    send_word(WORD_W'(99 * 8));
    send_word(WORD_W'(50 * 8 + 1));
    send_word('1);
    send_word(WORD_W'(3));
    cur_pop  = 100;
    cur_size = 8;

    while (words_sent < WORD_TARGET) begin
      settle();
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 6))
          0:       cur_pop = 1;
          1:       cur_pop = $urandom_range(2, 12);
          2:       cur_pop = $urandom_range(13, 300);
          3:       cur_pop = 65535;
          4:       cur_pop = $urandom_range(0, 1) ? 0 : 65534;
          default: cur_pop = $urandom_range(0, 65535);
        endcase
        write_reg(REG_POPULATION, POP_W'(cur_pop));
      end
      if ($urandom_range(0, 4) != 0) begin
        cur_size = $urandom_range(0, 15);
        write_reg(REG_SAMPLE, {(POP_W-SAMPLE_W)'($urandom), SAMPLE_W'(cur_size)});
      end
      pop_eff  = (cur_pop == 0) ? 1 : cur_pop;
      size_eff = (cur_size == 0) ? 1 : cur_size;
      if (size_eff > MAX_SAMPLE_DEF) size_eff = MAX_SAMPLE_DEF;
      if (size_eff > pop_eff) size_eff = pop_eff;
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      // mostly whole sets, now and then a partial one left behind
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, size_eff) : 0;
      count = size_eff * $urandom_range(1, 5) + extra;
      repeat (count) begin
        case ($urandom_range(0, 3))
          0:       word = WORD_W'($urandom_range(0, 63));
          1:       word = WORD_W'((pop_eff - 1) * 8 + $urandom_range(0, 7));
          default: word = WORD_W'($urandom);
        endcase
        send_word(word);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sswr_pkg.sv
rtl/core/sswr_rom.sv
rtl/core/sswr_seq.sv
rtl/core/sswr_datapath.sv
rtl/core/sorted_sample_without_replacement_unit.sv
rtl/core/sswr_checker.sv
sim/sample_set_checker.sv
sim/testbench.sv
